/* hdl/art_pkg.sv */
// Package with constants, codes and types shared by the tracker modules.
`timescale 1ns / 1ps
`default_nettype none
package art_pkg;

  localparam int unsigned TableDepthDef = 8;
  localparam int unsigned MaxResults    = 8;
  localparam int unsigned ResCntW       = $clog2(MaxResults + 1);

  // Input kinds.
  localparam logic [2:0] KIND_SEND       = 3'd0;
  localparam logic [2:0] KIND_ACK        = 3'd1;
  localparam logic [2:0] KIND_NACK       = 3'd2;
  localparam logic [2:0] KIND_TICK       = 3'd3;
  localparam logic [2:0] KIND_DISCONNECT = 3'd4;

  // Result events.
  localparam logic [2:0] EV_INSERTED     = 3'd0;
  localparam logic [2:0] EV_ACKED        = 3'd1;
  localparam logic [2:0] EV_RETRANSMIT   = 3'd2;
  localparam logic [2:0] EV_GAVE_UP_NACK = 3'd3;
  localparam logic [2:0] EV_GAVE_UP_TMO  = 3'd4;
  localparam logic [2:0] EV_TABLE_FULL   = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_MAX_RETRIES = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  localparam logic [3:0]  MaxRetriesRst = 4'd3;
  localparam logic [15:0] AckTimeoutRst = 16'd1000;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] send_time;
    logic [3:0]  retries;
  } entry_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] out_tag;
    logic [31:0] response_ms;
    logic [3:0]  retry_number;
    logic [31:0] acked_total;
    logic [31:0] nacked_total;
    logic [31:0] retries_total;
    logic [31:0] timeouts_total;
  } res_t;

endpackage
`default_nettype wire

/* hdl/art_result_stage.sv */
// Result staging: holds one result until the next one or the end of the item marks it last.
`timescale 1ns / 1ps
`default_nettype none
module art_result_stage
  import art_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  res_t      push_res_i,
  output logic      push_ok_o,
  input  wire logic close_i,
  output logic      close_ok_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output res_t      out_res_o,
  output logic      out_last_o
);

  logic pend_v_q;
  logic out_v_q;
  res_t pend_res_q;
  res_t out_res_q;
  logic out_last_q;
  logic out_free;
  logic do_push;
  logic do_close;

  assign out_free   = !out_v_q || !out_stall_i;
  assign push_ok_o  = !pend_v_q || out_free;
  assign close_ok_o = !pend_v_q || out_free;
  assign do_push    = push_i && push_ok_o;
  assign do_close   = close_i && pend_v_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else if (do_push) begin
      pend_v_q <= 1'b1;
      if (pend_v_q) begin
        out_v_q <= 1'b1;
      end else if (out_free) begin
        out_v_q <= 1'b0;
      end
    end else if (do_close) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b1;
    end else if (out_free) begin
      out_v_q <= 1'b0;
    end
  end

  // A pending result moves out as not last when a newer one arrives,
  // and as last when the item's work is finished.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      pend_res_q <= push_res_i;
      if (pend_v_q) begin
        out_res_q  <= pend_res_q;
        out_last_q <= 1'b0;
      end
    end else if (do_close) begin
      out_res_q  <= pend_res_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_res_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

/* hdl/ack_retransmit_tracker_unit.sv */
// Acknowledgement and retransmission tracker: table of sent messages awaiting an ack.
//
// Input channel: in_valid_i / in_stall_o with kind, msg_tag and now_ms. An item
// is taken when valid is high and stall is low; stall stays high while an item
// is being worked on. Output channel: out_valid_o / out_stall_i with one result
// per transfer; last_o marks the final result of an item. Sends, acks, nacks and
// ticks walk the table memory one entry per cycle, while no result is held
// back, through a single read port with a registered read; a send that misses
// every tag then places the entry in a free slot. A disconnect or an unused
// kind is handled without leaving idle. A result waits in a staging register
// until the next result of the same item, or the end of the item, decides its
// last flag; a stalled receiver holds the table walk only when a new result
// has no room. Reset clears the valid bits and the counters, and sets the retry
// limit to 3 and the acknowledgement timeout to 1000 ms. Configuration writes
// are always ready and are meant to be issued only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module ack_retransmit_tracker_unit
  import art_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [31:0] msg_tag_i,
  input  wire logic [31:0] now_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       event_res_o,
  output logic [31:0]      out_tag_o,
  output logic [31:0]      response_ms_o,
  output logic [3:0]       retry_number_o,
  output logic [31:0]      acked_total_o,
  output logic [31:0]      nacked_total_o,
  output logic [31:0]      retries_total_o,
  output logic [31:0]      timeouts_total_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_PLACE = 2'd2;
  localparam logic [1:0] ST_CLOSE = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [2:0]            kind_q;
  logic [31:0]           tag_q, now_q;
  logic [3:0]            max_q;
  logic [15:0]           tmo_q;
  logic [TableDepth-1:0] vld_q, vld_d;
  logic [CntW-1:0]       rd_cnt_q, rd_cnt_d;
  logic                  rd_v_q, rd_v_d;
  logic [IdxW-1:0]       ev_idx_q, ev_idx_d;
  logic [ResCntW-1:0]    res_cnt_q, res_cnt_d;
  logic [31:0]           acked_q, acked_d;
  logic [31:0]           nacked_q, nacked_d;
  logic [31:0]           retries_q, retries_d;
  logic [31:0]           tmos_q, tmos_d;

  entry_t                mem [TableDepth];
  entry_t                rd_q;
  logic                  mem_we;
  logic [IdxW-1:0]       mem_wa;
  entry_t                mem_wd;
  logic                  rd_en;

  logic                  accept;
  logic                  push, push_ok, close, close_ok;
  res_t                  push_res, out_res;

  // Evaluation of the entry held in the read register.
  logic [31:0]           elapsed;
  logic                  hit, expired, can_retry;
  logic                  t_need, t_we, t_clr, t_stop;
  logic                  inc_ack, inc_nack, inc_retry, inc_tmo;
  logic [2:0]            t_ev;
  logic [31:0]           t_tag, t_resp;
  logic [3:0]            t_retry;
  entry_t                t_wd;
  logic                  ev_go, consumed, stop_eff, more, issue;
  logic                  free_found;
  logic [IdxW-1:0]       free_idx;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign elapsed   = now_q - rd_q.send_time;
  assign hit       = vld_q[ev_idx_q] && (rd_q.tag == tag_q);
  assign expired   = vld_q[ev_idx_q] && (elapsed > {16'd0, tmo_q});
  assign can_retry = rd_q.retries < max_q;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (!vld_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  always_comb begin
    t_need    = 1'b0;
    t_we      = 1'b0;
    t_clr     = 1'b0;
    t_stop    = 1'b0;
    inc_ack   = 1'b0;
    inc_nack  = 1'b0;
    inc_retry = 1'b0;
    inc_tmo   = 1'b0;
    t_ev      = EV_INSERTED;
    t_tag     = rd_q.tag;
    t_resp    = '0;
    t_retry   = rd_q.retries;
    t_wd      = '{tag: rd_q.tag, send_time: now_q, retries: rd_q.retries + 4'd1};
    if (state_q == ST_SCAN && rd_v_q) begin
      case (kind_q)
        KIND_SEND: begin
          if (hit) begin
            t_need  = 1'b1;
            t_we    = 1'b1;
            t_stop  = 1'b1;
            t_ev    = EV_INSERTED;
            t_tag   = tag_q;
            t_retry = '0;
            t_wd    = '{tag: tag_q, send_time: now_q, retries: 4'd0};
          end
        end
        KIND_ACK: begin
          if (hit) begin
            t_need  = 1'b1;
            t_clr   = 1'b1;
            t_stop  = 1'b1;
            inc_ack = 1'b1;
            t_ev    = EV_ACKED;
            t_resp  = elapsed;
          end
        end
        KIND_NACK: begin
          if (hit) begin
            t_need   = 1'b1;
            t_stop   = 1'b1;
            inc_nack = 1'b1;
            if (can_retry) begin
              t_we      = 1'b1;
              inc_retry = 1'b1;
              t_ev      = EV_RETRANSMIT;
              t_retry   = rd_q.retries + 4'd1;
            end else begin
              t_clr = 1'b1;
              t_ev  = EV_GAVE_UP_NACK;
            end
          end
        end
        KIND_TICK: begin
          if (expired) begin
            t_need = 1'b1;
            t_stop = (res_cnt_q + ResCntW'(1)) == ResCntW'(MaxResults);
            if (can_retry) begin
              t_we      = 1'b1;
              inc_retry = 1'b1;
              t_ev      = EV_RETRANSMIT;
              t_retry   = rd_q.retries + 4'd1;
            end else begin
              t_clr   = 1'b1;
              inc_tmo = 1'b1;
              t_ev    = EV_GAVE_UP_TMO;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign ev_go    = !t_need || push_ok;
  assign consumed = !rd_v_q || ev_go;
  assign stop_eff = rd_v_q && ev_go && t_stop;
  assign more     = (rd_cnt_q != CntW'(TableDepth)) && !stop_eff;
  assign issue    = (state_q == ST_SCAN) && consumed && more;

  always_comb begin
    state_d   = state_q;
    vld_d     = vld_q;
    rd_cnt_d  = rd_cnt_q;
    rd_v_d    = rd_v_q;
    ev_idx_d  = ev_idx_q;
    res_cnt_d = res_cnt_q;
    acked_d   = acked_q;
    nacked_d  = nacked_q;
    retries_d = retries_q;
    tmos_d    = tmos_q;
    mem_we    = 1'b0;
    mem_wa    = ev_idx_q;
    mem_wd    = t_wd;
    rd_en     = 1'b0;
    push      = 1'b0;
    close     = 1'b0;
    push_res  = '{event_res: t_ev, out_tag: t_tag, response_ms: t_resp,
                  retry_number: t_retry,
                  acked_total: acked_q + {31'd0, inc_ack},
                  nacked_total: nacked_q + {31'd0, inc_nack},
                  retries_total: retries_q + {31'd0, inc_retry},
                  timeouts_total: tmos_q + {31'd0, inc_tmo}};
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (kind_i inside {KIND_SEND, KIND_ACK, KIND_NACK, KIND_TICK}) begin
            state_d   = ST_SCAN;
            rd_cnt_d  = '0;
            rd_v_d    = 1'b0;
            res_cnt_d = '0;
          end else if (kind_i == KIND_DISCONNECT) begin
            vld_d = '0;
          end
        end
      end
      ST_SCAN: begin
        if (rd_v_q && t_need && ev_go) begin
          push      = 1'b1;
          mem_we    = t_we;
          acked_d   = push_res.acked_total;
          nacked_d  = push_res.nacked_total;
          retries_d = push_res.retries_total;
          tmos_d    = push_res.timeouts_total;
          res_cnt_d = res_cnt_q + ResCntW'(1);
          if (t_clr) begin
            vld_d[ev_idx_q] = 1'b0;
          end
        end
        if (issue) begin
          rd_en    = 1'b1;
          rd_cnt_d = rd_cnt_q + CntW'(1);
          ev_idx_d = rd_cnt_q[IdxW-1:0];
          rd_v_d   = 1'b1;
        end else if (consumed) begin
          rd_v_d = 1'b0;
          // A send that matched no tag still has to take a free slot.
          if (kind_q == KIND_SEND && !stop_eff) begin
            state_d = ST_PLACE;
          end else begin
            state_d = ST_CLOSE;
          end
        end
      end
      ST_PLACE: begin
        push_res = '{event_res: free_found ? EV_INSERTED : EV_TABLE_FULL,
                     out_tag: tag_q, response_ms: '0, retry_number: '0,
                     acked_total: acked_q, nacked_total: nacked_q,
                     retries_total: retries_q, timeouts_total: tmos_q};
        mem_wa   = free_idx;
        mem_wd   = '{tag: tag_q, send_time: now_q, retries: 4'd0};
        if (push_ok) begin
          push    = 1'b1;
          state_d = ST_CLOSE;
          if (free_found) begin
            mem_we          = 1'b1;
            vld_d[free_idx] = 1'b1;
          end
        end
      end
      ST_CLOSE: begin
        close = 1'b1;
        if (close_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vld_q     <= '0;
      rd_cnt_q  <= '0;
      rd_v_q    <= 1'b0;
      ev_idx_q  <= '0;
      res_cnt_q <= '0;
      acked_q   <= '0;
      nacked_q  <= '0;
      retries_q <= '0;
      tmos_q    <= '0;
      max_q     <= MaxRetriesRst;
      tmo_q     <= AckTimeoutRst;
    end else begin
      state_q   <= state_d;
      vld_q     <= vld_d;
      rd_cnt_q  <= rd_cnt_d;
      rd_v_q    <= rd_v_d;
      ev_idx_q  <= ev_idx_d;
      res_cnt_q <= res_cnt_d;
      acked_q   <= acked_d;
      nacked_q  <= nacked_d;
      retries_q <= retries_d;
      tmos_q    <= tmos_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_MAX_RETRIES: max_q <= cfg_data_i[3:0];
          CFG_ACK_TIMEOUT: tmo_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      tag_q  <= msg_tag_i;
      now_q  <= now_ms_i;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q <= mem[rd_cnt_q[IdxW-1:0]];
    end
  end

  art_result_stage u_result_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_res_i  (push_res),
    .push_ok_o   (push_ok),
    .close_i     (close),
    .close_ok_o  (close_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res),
    .out_last_o  (last_o)
  );

  assign event_res_o      = out_res.event_res;
  assign out_tag_o        = out_res.out_tag;
  assign response_ms_o    = out_res.response_ms;
  assign retry_number_o   = out_res.retry_number;
  assign acked_total_o    = out_res.acked_total;
  assign nacked_total_o   = out_res.nacked_total;
  assign retries_total_o  = out_res.retries_total;
  assign timeouts_total_o = out_res.timeouts_total;

endmodule
`default_nettype wire

/* verif/art_checker.sv */
// Checker that predicts the tracker's results from observed transfers and compares them.
`timescale 1ns / 1ps
module art_checker
  import art_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [2:0]  kind_i,
  input  wire logic [31:0] msg_tag_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [2:0]  event_res_i,
  input  wire logic [31:0] out_tag_i,
  input  wire logic [31:0] response_ms_i,
  input  wire logic [3:0]  retry_number_i,
  input  wire logic [31:0] acked_total_i,
  input  wire logic [31:0] nacked_total_i,
  input  wire logic [31:0] retries_total_i,
  input  wire logic [31:0] timeouts_total_i,
  input  wire logic        last_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output int unsigned      fail_cnt_o,
  output int unsigned      pending_o
);

  localparam int Depth = TableDepthDef;

  typedef struct packed {
    res_t res;
    logic last;
  } tracker_result_t;

  tracker_result_t awaited_events[$];

  logic        slot_used    [Depth];
  logic [31:0] slot_tag     [Depth];
  logic [31:0] slot_sent    [Depth];
  logic [3:0]  slot_retries [Depth];
  logic [31:0] acked_cnt;
  logic [31:0] nacked_cnt;
  logic [31:0] retried_cnt;
  logic [31:0] timed_out_cnt;
  logic [3:0]  retry_limit;
  logic [15:0] timeout_ms;
  int unsigned fail_cnt = 0;
  int unsigned item_events;

  function automatic int find_tag(logic [31:0] tag);
    for (int i = 0; i < Depth; i++) begin
      if (slot_used[i] && slot_tag[i] == tag) return i;
    end
    return -1;
  endfunction

  function automatic int find_free();
    for (int i = 0; i < Depth; i++) begin
      if (!slot_used[i]) return i;
    end
    return -1;
  endfunction

  function automatic bit field_ok(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Counters are taken as they stand after the update that causes the event.
  task automatic add_event(logic [2:0] ev, logic [31:0] tag, logic [31:0] resp,
                           logic [3:0] retry);
    tracker_result_t r;
    r.res.event_res      = ev;
    r.res.out_tag        = tag;
    r.res.response_ms    = resp;
    r.res.retry_number   = retry;
    r.res.acked_total    = acked_cnt;
    r.res.nacked_total   = nacked_cnt;
    r.res.retries_total  = retried_cnt;
    r.res.timeouts_total = timed_out_cnt;
    r.last               = 1'b0;
    awaited_events.push_back(r);
    item_events++;
  endtask

  task automatic predict_item(logic [2:0] kind, logic [31:0] tag, logic [31:0] now);
    int slot;
    logic [31:0] elapsed;
    tracker_result_t tail;
    item_events = 0;
    case (kind)
      KIND_SEND: begin
        slot = find_tag(tag);
        if (slot < 0) slot = find_free();
        if (slot < 0) begin
          add_event(EV_TABLE_FULL, tag, '0, '0);
        end else begin
          slot_used[slot]    = 1'b1;
          slot_tag[slot]     = tag;
          slot_sent[slot]    = now;
          slot_retries[slot] = '0;
          add_event(EV_INSERTED, tag, '0, '0);
        end
      end
      KIND_ACK: begin
        slot = find_tag(tag);
        if (slot >= 0) begin
          acked_cnt++;
          slot_used[slot] = 1'b0;
          add_event(EV_ACKED, tag, now - slot_sent[slot], slot_retries[slot]);
        end
      end
      KIND_NACK: begin
        slot = find_tag(tag);
        if (slot >= 0) begin
          nacked_cnt++;
          if (slot_retries[slot] < retry_limit) begin
            slot_retries[slot]++;
            slot_sent[slot] = now;
            retried_cnt++;
            add_event(EV_RETRANSMIT, tag, '0, slot_retries[slot]);
          end else begin
            slot_used[slot] = 1'b0;
            add_event(EV_GAVE_UP_NACK, tag, '0, slot_retries[slot]);
          end
        end
      end
      KIND_TICK: begin
        for (int i = 0; i < Depth; i++) begin
          elapsed = now - slot_sent[i];
          if (slot_used[i] && elapsed > {16'h0, timeout_ms}) begin
            if (slot_retries[i] < retry_limit) begin
              slot_retries[i]++;
              slot_sent[i] = now;
              retried_cnt++;
              add_event(EV_RETRANSMIT, slot_tag[i], '0, slot_retries[i]);
            end else begin
              timed_out_cnt++;
              slot_used[i] = 1'b0;
              add_event(EV_GAVE_UP_TMO, slot_tag[i], '0, slot_retries[i]);
            end
          end
        end
      end
      KIND_DISCONNECT: begin
        for (int i = 0; i < Depth; i++) slot_used[i] = 1'b0;
      end
      default: ;
    endcase
    if (item_events > 0) begin
      tail = awaited_events.pop_back();
      tail.last = 1'b1;
      awaited_events.push_back(tail);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tracker_result_t want;
    bit ok;
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        slot_used[i]    = 1'b0;
        slot_tag[i]     = '0;
        slot_sent[i]    = '0;
        slot_retries[i] = '0;
      end
      acked_cnt     = '0;
      nacked_cnt    = '0;
      retried_cnt   = '0;
      timed_out_cnt = '0;
      retry_limit   = MaxRetriesRst;
      timeout_ms    = AckTimeoutRst;
      awaited_events.delete();
      pending_o  <= 0;
      fail_cnt_o <= fail_cnt;
    end else begin
      // Results are checked before the input of the same edge is predicted; a result
      // can never come from an item that is only now being accepted.
      if (out_valid_i && !out_stall_i) begin
        if (awaited_events.size() == 0) begin
          $display("%0t: unexpected result, event %0d tag %0h", $time, event_res_i,
                   out_tag_i);
          fail_cnt++;
        end else begin
          want = awaited_events.pop_front();
          ok = 1'b1;
          ok &= field_ok("event_res", want.res.event_res, event_res_i);
          ok &= field_ok("out_tag", want.res.out_tag, out_tag_i);
          ok &= field_ok("response_ms", want.res.response_ms, response_ms_i);
          ok &= field_ok("retry_number", want.res.retry_number, retry_number_i);
          ok &= field_ok("acked_total", want.res.acked_total, acked_total_i);
          ok &= field_ok("nacked_total", want.res.nacked_total, nacked_total_i);
          ok &= field_ok("retries_total", want.res.retries_total, retries_total_i);
          ok &= field_ok("timeouts_total", want.res.timeouts_total, timeouts_total_i);
          ok &= field_ok("last", want.last, last_i);
          if (!ok) fail_cnt++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MAX_RETRIES: retry_limit = cfg_data_i[3:0];
          CFG_ACK_TIMEOUT: timeout_ms  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_item(kind_i, msg_tag_i, now_ms_i);
      pending_o  <= awaited_events.size();
      fail_cnt_o <= fail_cnt;
    end
  end

endmodule

/* verif/tb_top.sv */
// Testbench top: drives traffic and register writes into the tracker and reports the verdict.
`timescale 1ns / 1ps
module tb_top;
  import art_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned PoolSize     = 10;
  localparam logic [2:0]  KindUnusedLo = 3'd5;
  localparam logic [2:0]  KindUnusedHi = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  kind = KIND_SEND;
  logic [31:0] msg_tag = '0;
  logic [31:0] now_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  event_res;
  logic [31:0] out_tag;
  logic [31:0] response_ms;
  logic [3:0]  retry_number;
  logic [31:0] acked_total;
  logic [31:0] nacked_total;
  logic [31:0] retries_total;
  logic [31:0] timeouts_total;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_MAX_RETRIES;
  logic [15:0] cfg_data = '0;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  logic [31:0] clock_ms = '0;
  int unsigned tmo_cur = AckTimeoutRst;
  logic [31:0] tag_pool [PoolSize];

  ack_retransmit_tracker_unit u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .kind_i          (kind),
    .msg_tag_i       (msg_tag),
    .now_ms_i        (now_ms),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .event_res_o     (event_res),
    .out_tag_o       (out_tag),
    .response_ms_o   (response_ms),
    .retry_number_o  (retry_number),
    .acked_total_o   (acked_total),
    .nacked_total_o  (nacked_total),
    .retries_total_o (retries_total),
    .timeouts_total_o(timeouts_total),
    .last_o          (last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  art_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .kind_i          (kind),
    .msg_tag_i       (msg_tag),
    .now_ms_i        (now_ms),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .event_res_i     (event_res),
    .out_tag_i       (out_tag),
    .response_ms_i   (response_ms),
    .retry_number_i  (retry_number),
    .acked_total_i   (acked_total),
    .nacked_total_i  (nacked_total),
    .retries_total_i (retries_total),
    .timeouts_total_i(timeouts_total),
    .last_i          (last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("[ack_retransmit_tracker_unit] ERROR");
      $finish;
    end
  end

  // Receiver side: random stalls, plus one long hold-off so the tracker backs up.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Valid is left high after a transfer; the next call either lowers it or
  // replaces the payload in the same step.
  task automatic offer(logic [2:0] k, logic [31:0] tag, logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    msg_tag  <= tag;
    now_ms   <= t;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic program_limits(logic [3:0] retries, logic [15:0] tmo);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAX_RETRIES;
    cfg_data  <= {12'($urandom), retries};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_ACK_TIMEOUT;
    cfg_data  <= tmo;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tmo_cur = tmo;
  endtask

  task automatic advance_clock();
    case ($urandom_range(9))
      0: ;
      1: clock_ms += tmo_cur + 1;
      2: clock_ms += $urandom;
      default: clock_ms += $urandom_range(tmo_cur + tmo_cur / 2 + 2);
    endcase
  endtask

  task automatic directed_items();
    logic [31:0] t0;
    t0 = 32'hFFFF_FF00;
    offer(KIND_SEND, 32'h0000_0000, t0);
    offer(KIND_SEND, 32'hFFFF_FFFF, t0 + 1);
    for (int k = 1; k <= 6; k++) offer(KIND_SEND, 32'hA5A5_0000 + k, t0 + 2);
    offer(KIND_SEND, 32'h5A5A_5A5A, t0 + 3);
    // A send with a known tag restarts the entry in place.
    offer(KIND_SEND, 32'h0000_0000, t0 + 4);
    // The response time of this ack wraps past zero.
    offer(KIND_ACK, 32'hFFFF_FFFF, t0 + 32'h200);
    offer(KIND_ACK, 32'h1234_5678, t0 + 32'h200);
    offer(KIND_NACK, 32'h8765_4321, t0 + 32'h200);
    for (int k = 0; k < 4; k++) offer(KIND_NACK, 32'hA5A5_0001, t0 + 32'h210 + k);
    offer(KIND_TICK, 32'h0000_0000, t0 + 32'h220);
    // Entries sent at t0 + 2 expire; the one restarted at t0 + 4 sits exactly on the limit.
    offer(KIND_TICK, 32'h0000_0000, t0 + 1004);
    offer(KIND_TICK, 32'hFFFF_FFFF, t0 + 1004);
    for (int k = KindUnusedLo; k <= KindUnusedHi; k++) offer(3'(k), $urandom, $urandom);
    offer(KIND_DISCONNECT, 32'h0000_0000, t0 + 1100);
    offer(KIND_SEND, 32'hC3C3_C3C3, t0 + 1100);
    offer(KIND_TICK, 32'h0000_0000, t0 + 2200);
    clock_ms = t0 + 2200;
  endtask

  // Mostly sends, acks and nacks on a small tag pool so lookups hit, with ticks
  // and some stray tags, disconnects and unused kinds mixed in.
  task automatic random_traffic(int unsigned count);
    int unsigned done;
    int unsigned pick;
    logic [31:0] tag;
    done = 0;
    while (done < count) begin
      advance_clock();
      pick = $urandom_range(99);
      tag = tag_pool[$urandom_range(PoolSize - 1)];
      if (pick < 35) begin
        offer(KIND_SEND, tag, clock_ms);
      end else if (pick < 55) begin
        offer(KIND_ACK, tag, clock_ms);
      end else if (pick < 73) begin
        offer(KIND_NACK, tag, clock_ms);
      end else if (pick < 90) begin
        offer(KIND_TICK, $urandom, clock_ms);
      end else if (pick < 93) begin
        offer(KIND_DISCONNECT, $urandom, clock_ms);
      end else if (pick < 97) begin
        offer(3'($urandom_range(KIND_SEND, KIND_NACK)), $urandom, clock_ms);
      end else begin
        offer(3'($urandom_range(KindUnusedLo, KindUnusedHi)), $urandom, $urandom);
        continue;
      end
      done++;
    end
  endtask

  initial begin
    for (int i = 0; i < PoolSize; i++) tag_pool[i] = $urandom;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 21;
    recv_idle_pct <= 47;
    directed_items();
    settle();

    // No retries and a zero timeout: the surviving entry gives up at once.
    program_limits(4'd0, 16'd0);
    offer(KIND_TICK, 32'h0000_0000, clock_ms + 1);
    random_traffic(40);
    settle();

    send_idle_pct = 47;
    recv_idle_pct <= 21;
    program_limits(4'd15, 16'hFFFF);
    random_traffic(10);
    hold_req <= 1'b1;
    random_traffic(50);
    settle();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    program_limits(4'($urandom_range(1, 14)), 16'($urandom_range(2, 3000)));
    random_traffic(60);
    settle();

    program_limits(4'd2, 16'd1);
    random_traffic(50);
    settle();

    if (fail_cnt == 0 && pending == 0) begin
      $display("[ack_retransmit_tracker_unit] OK");
    end else begin
      $display("[ack_retransmit_tracker_unit] ERROR");
    end
    $finish;
  end

endmodule
